@@ rtl/cer_pkg.sv @@
// ---------------------------------------------------------------------------
// cer_pkg: shared definitions for the coalescing event ring
// Depth, pointer width, command and event-kind codes, register map.
// ---------------------------------------------------------------------------
package cer_pkg;

    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam int TYPE_W  = 4;
    localparam int COORD_W = 32;
    localparam int DIST_W  = 16;

    // Input tuser: command, event type. Output tuser: ok, merged, dropped, type.
    localparam int S_TUSER_W = 1 + TYPE_W;
    localparam int M_TUSER_W = 3 + TYPE_W;
    localparam int TDATA_W   = 2 * COORD_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic       CMD_PUT = 1'b0;
    localparam logic       CMD_POP = 1'b1;

    localparam logic [TYPE_W-1:0] EVT_WIN_MOVE   = 4'd1;
    localparam logic [TYPE_W-1:0] EVT_WIN_RESIZE = 4'd2;
    localparam logic [TYPE_W-1:0] EVT_MOUSE_MOVE = 4'd3;

    localparam logic [DIST_W-1:0] DIST_RESET = 16'd15;

    // Register index, taken from paddr[2].
    localparam logic REG_COALESCE_DIST = 1'b0;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef struct packed {
        logic [TYPE_W-1:0]         etype;
        logic signed [COORD_W-1:0] first;
        logic signed [COORD_W-1:0] second;
    } entry_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        ptr_t r;
        if (p == '0) begin
            r = ptr_t'(RING_DEPTH - 1);
        end else begin
            r = p - ptr_t'(1);
        end
        return r;
    endfunction

endpackage

@@ rtl/coalescing_event_ring.sv @@
// ---------------------------------------------------------------------------
// coalescing_event_ring: event queue with coalescing of move events
// A ring of event entries fed by put and pop commands. Puts of move, resize
// or mouse-move events fold into the newest entry when close enough.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid / s_tready  tuser: command, event type
//                                            tdata: first, second coordinate
//  m_        out        m_tvalid / m_tready  tuser: ok, merged, dropped, type
//                                            tdata: first, second coordinate
//  APB       in         psel / penable       coalesce distance at byte addr 0
//
// Each accepted word is held in an input register; when it is processed, its result
// word is loaded into the output register and offered on m_. One word can be taken
// every cycle while m_ does not stall. A stall on m_ holds the output register; a word
// waiting in the input register is then held as well and s_tready stays low until
// the result moves on. Reset is synchronous and active low; it empties the ring and
// restores a coalesce distance of 15.
//
module coalescing_event_ring
    import cer_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [31:0] coord_first, [63:32] coord_second
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] command, [4:1] event_type

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [31:0] out_first, [63:32] out_second
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] ok, [1] merged, [2] dropped_oldest,
                                            // [6:3] out_type

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    // -----------------------------------------------------------------------
    // Configuration register. Writes are expected only while no word is in
    // flight.
    // -----------------------------------------------------------------------
    logic [DIST_W-1:0] dist_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_COALESCE_DIST);
    assign prdata    = (paddr[2] == REG_COALESCE_DIST) ?
                       {{(APB_DW-DIST_W){1'b0}}, dist_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= DIST_RESET;
        end else if (cfg_write) begin
            dist_reg <= pwdata[DIST_W-1:0];
        end
    end

    // -----------------------------------------------------------------------
    // Input register stage.
    // -----------------------------------------------------------------------
    logic   in_valid_reg;
    logic   in_cmd_reg;
    entry_t in_evt_reg;
    logic   step;       // the held word is processed at this edge

    assign step     = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg        <= s_tuser[0];
            in_evt_reg.etype  <= s_tuser[S_TUSER_W-1:1];
            in_evt_reg.first  <= s_tdata[COORD_W-1:0];
            in_evt_reg.second <= s_tdata[TDATA_W-1:COORD_W];
        end
    end

    // -----------------------------------------------------------------------
    // Ring state. The entry array is read only at the read pointer; the newest
    // entry is mirrored in its own register so the coalesce check needs no
    // second read port. Entries are payload and are never cleared.
    // -----------------------------------------------------------------------
    entry_t ring_mem [RING_DEPTH];
    entry_t newest_reg;
    ptr_t   wr_ptr_reg, rd_ptr_reg;
    logic   full_reg;

    logic   ring_empty;
    logic   is_pop, pop_ok, coal_kind, merge, append;
    logic   near_first, near_second;
    ptr_t   wr_ptr_inc, rd_ptr_inc, rd_ptr_after;
    entry_t oldest;

    // Exact 33-bit differences so extreme coordinates never wrap into a merge.
    logic signed [COORD_W:0] diff_first, diff_second;
    logic        [COORD_W:0] abs_first, abs_second;

    assign ring_empty = !full_reg && (wr_ptr_reg == rd_ptr_reg);
    assign is_pop     = (in_cmd_reg == CMD_POP);
    assign pop_ok     = is_pop && !ring_empty;
    assign coal_kind  = (in_evt_reg.etype == EVT_WIN_MOVE)   ||
                        (in_evt_reg.etype == EVT_WIN_RESIZE) ||
                        (in_evt_reg.etype == EVT_MOUSE_MOVE);

    assign diff_first  = {newest_reg.first[COORD_W-1], newest_reg.first} -
                         {in_evt_reg.first[COORD_W-1], in_evt_reg.first};
    assign diff_second = {newest_reg.second[COORD_W-1], newest_reg.second} -
                         {in_evt_reg.second[COORD_W-1], in_evt_reg.second};
    assign abs_first   = diff_first[COORD_W]  ? -diff_first  : diff_first;
    assign abs_second  = diff_second[COORD_W] ? -diff_second : diff_second;
    assign near_first  = abs_first  <= {{(COORD_W+1-DIST_W){1'b0}}, dist_reg};
    assign near_second = abs_second <= {{(COORD_W+1-DIST_W){1'b0}}, dist_reg};

    assign merge  = !is_pop && !ring_empty && coal_kind &&
                    (newest_reg.etype == in_evt_reg.etype) && near_first && near_second;
    assign append = !is_pop && !merge;

    assign wr_ptr_inc   = ptr_inc(wr_ptr_reg);
    assign rd_ptr_inc   = ptr_inc(rd_ptr_reg);
    // An append into a full ring pushes the oldest entry out.
    assign rd_ptr_after = full_reg ? rd_ptr_inc : rd_ptr_reg;
    assign oldest       = ring_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            full_reg   <= 1'b0;
        end else if (step) begin
            if (pop_ok) begin
                rd_ptr_reg <= rd_ptr_inc;
                full_reg   <= 1'b0;
            end else if (append) begin
                wr_ptr_reg <= wr_ptr_inc;
                rd_ptr_reg <= rd_ptr_after;
                full_reg   <= (wr_ptr_inc == rd_ptr_after);
            end
        end
    end

    // A merge rewrites the coordinates of the newest slot, just behind wr_ptr.
    always_ff @(posedge aclk) begin
        if (step && append) begin
            ring_mem[wr_ptr_reg] <= in_evt_reg;
            newest_reg           <= in_evt_reg;
        end else if (step && merge) begin
            ring_mem[ptr_dec(wr_ptr_reg)] <= in_evt_reg;
            newest_reg.first              <= in_evt_reg.first;
            newest_reg.second             <= in_evt_reg.second;
        end
    end

    // -----------------------------------------------------------------------
    // Output register.
    // -----------------------------------------------------------------------
    logic                m_valid_reg;
    logic [TDATA_W-1:0]  m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_user_reg <= {(pop_ok ? oldest.etype : {TYPE_W{1'b0}}),
                           append && full_reg,
                           merge,
                           !is_pop || pop_ok};
            m_data_reg <= pop_ok ? {oldest.second, oldest.first} : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ rtl/cer_checker.sv @@
// ---------------------------------------------------------------------------
// cer_checker: port-level checks for the coalescing event ring
// Watches the result channel and reset behaviour; bound to the top level.
// ---------------------------------------------------------------------------
module cer_checker
    import cer_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [TDATA_W-1:0]   m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A failed pop carries nothing but zeros.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && (m_tuser[M_TUSER_W-1:1] == '0))
        else $error("failed pop carries non-zero fields");

    // A merge never drops an entry and never returns an event.
    a_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && !m_tuser[2] &&
                                   (m_tdata == '0) && (m_tuser[M_TUSER_W-1:3] == '0))
        else $error("merge result inconsistent");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind coalescing_event_ring cer_checker u_cer_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
